FILE: design/pf_pkg.sv
// Shared types, constants and lookup functions for the digraph cipher unit.
package pf_pkg;

  typedef logic [4:0] letter_t;
  typedef letter_t [4:0] row_t;
  typedef row_t [4:0] square_t;
  typedef logic [2:0] coord_t;

  typedef enum logic [2:0] {
    REG_DECRYPT = 3'd0,
    REG_ROW0    = 3'd1,
    REG_ROW1    = 3'd2,
    REG_ROW2    = 3'd3,
    REG_ROW3    = 3'd4,
    REG_ROW4    = 3'd5
  } reg_idx_e;

  localparam letter_t LETTER_I = 5'd8;
  localparam letter_t LETTER_J = 5'd9;
  localparam letter_t LETTER_X = 5'd23;
  localparam coord_t SHIFT_ENC = 3'd1;
  localparam coord_t SHIFT_DEC = 3'd4;

  localparam row_t ROW0_RESET = 25'd4294688;
  localparam row_t ROW1_RESET = 25'd10755269;
  localparam row_t ROW2_RESET = 25'd16201099;
  localparam row_t ROW3_RESET = 25'd21613104;
  localparam row_t ROW4_RESET = 25'd27025109;

  typedef struct packed {
    logic    decrypt;
    square_t square;
  } cfg_t;

  typedef struct packed {
    letter_t a;
    letter_t b;
    logic    two;   // pair is emitted twice (doubled letter on the final item)
    logic    last;
  } pair_t;

  typedef struct packed {
    coord_t row;
    coord_t col;
  } pos_t;

  function automatic letter_t fold_j(letter_t l);
    return (l == LETTER_J) ? LETTER_I : l;
  endfunction

  // First match in row-major order; a missing letter lands at row 0, column 0.
  function automatic pos_t locate(square_t sq, letter_t l);
    pos_t p;
    p = '0;
    for (int r = 4; r >= 0; r--) begin
      for (int c = 4; c >= 0; c--) begin
        if (sq[r][c] == l) begin
          p.row = coord_t'(r);
          p.col = coord_t'(c);
        end
      end
    end
    return p;
  endfunction

  function automatic coord_t add_mod5(coord_t v, coord_t s);
    logic [3:0] t;
    t = {1'b0, v} + {1'b0, s};
    if (t >= 4'd5) begin
      t = t - 4'd5;
    end
    return t[2:0];
  endfunction

endpackage

FILE: design/playfair_digraph_cipher_unit.sv
// Top level of the digraph cipher unit: config registers, pairing and cipher stages.
//
// Input channel: in_valid_i / in_stall_o carry one letter (a=0..z=25) and a
// final-letter flag; an item is taken when valid is high and stall is low.
// Output channel: out_valid_o / out_stall_i carry one ciphered letter per
// transfer, with out_last_o on the final letter of a message.
// Config channel: cfg_valid_i / cfg_ready_o write register cfg_index_i
// (0 direction, 1..5 key square rows); ready is always high. Write only
// while no letters are in flight.
// The first letter of a pair passes through the pair register and then the
// output register before it is on the output.
// Throughput: the output register drains one letter per cycle while the
// receiver does not stall, and a pair occupies the pair register until its
// last letter is loaded into the output register; a hold-only item needs an
// accept of its own.
// A new item is accepted in the cycle the pair register hands off its last
// letter, so there is no bubble between pairs.
// Reset clears the pending letter, all valids, encrypt mode and loads the
// a..z (no j) square. A stalled receiver holds the output register, then
// the pair register, then stalls the input.
module playfair_digraph_cipher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  in_letter_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  out_letter_o,
  output logic        out_last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [24:0] cfg_data_i
);
  import pf_pkg::*;

  cfg_t  cfg;
  pair_t pair;
  logic  pair_valid;
  logic  pair_stall;

  pf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pf_pair u_pair (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .decrypt_i    (cfg.decrypt),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_letter_i  (in_letter_i),
    .in_last_i    (in_last_i),
    .pair_stall_i (pair_stall),
    .pair_valid_o (pair_valid),
    .pair_o       (pair)
  );

  pf_cipher u_cipher (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .pair_valid_i (pair_valid),
    .pair_i       (pair),
    .pair_stall_o (pair_stall),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_letter_o (out_letter_o),
    .out_last_o   (out_last_o)
  );

endmodule

FILE: design/pf_cfg_regs.sv
// Configuration registers: cipher direction and the 5x5 key square.
module pf_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [24:0]      cfg_data_i,
  output pf_pkg::cfg_t     cfg_o
);
  import pf_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decrypt   <= 1'b0;
      cfg_q.square[0] <= ROW0_RESET;
      cfg_q.square[1] <= ROW1_RESET;
      cfg_q.square[2] <= ROW2_RESET;
      cfg_q.square[3] <= ROW3_RESET;
      cfg_q.square[4] <= ROW4_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_idx_e'(cfg_index_i))
        REG_DECRYPT: cfg_q.decrypt   <= cfg_data_i[0];
        REG_ROW0:    cfg_q.square[0] <= cfg_data_i;
        REG_ROW1:    cfg_q.square[1] <= cfg_data_i;
        REG_ROW2:    cfg_q.square[2] <= cfg_data_i;
        REG_ROW3:    cfg_q.square[3] <= cfg_data_i;
        REG_ROW4:    cfg_q.square[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

FILE: design/pf_pair.sv
// Letter pairing: pending-letter register, doubled-letter filler and tail padding.
module pf_pair (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             decrypt_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [4:0]       in_letter_i,
  input  logic             in_last_i,
  input  logic             pair_stall_i,
  output logic             pair_valid_o,
  output pf_pkg::pair_t    pair_o
);
  import pf_pkg::*;

  letter_t held_letter_q, held_letter_d;
  logic    held_valid_q, held_valid_d;
  letter_t letter;
  logic    emit;
  logic    accept;

  assign in_stall_o = pair_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign letter     = fold_j(in_letter_i);

  always_comb begin
    held_letter_d = held_letter_q;
    held_valid_d  = held_valid_q;
    emit          = 1'b0;
    pair_o        = '{a: letter, b: LETTER_X, two: 1'b0, last: in_last_i};
    if (!held_valid_q) begin
      if (in_last_i) begin
        emit = 1'b1;
      end else begin
        held_letter_d = letter;
        held_valid_d  = 1'b1;
      end
    end else if (!decrypt_i && (letter == held_letter_q)) begin
      emit          = 1'b1;
      pair_o.a      = held_letter_q;
      pair_o.two    = in_last_i;
      held_letter_d = letter;
      held_valid_d  = !in_last_i;
    end else begin
      emit         = 1'b1;
      pair_o.a     = held_letter_q;
      pair_o.b     = letter;
      held_valid_d = 1'b0;
    end
  end

  assign pair_valid_o = accept && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_letter_q <= '0;
      held_valid_q  <= 1'b0;
    end else if (accept) begin
      held_letter_q <= held_letter_d;
      held_valid_q  <= held_valid_d;
    end
  end

endmodule

FILE: design/pf_cipher.sv
// Pair register, key square lookup and output register, one letter per cycle while the receiver does not stall.
module pf_cipher (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pf_pkg::cfg_t     cfg_i,
  input  logic             pair_valid_i,
  input  pf_pkg::pair_t    pair_i,
  output logic             pair_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [4:0]       out_letter_o,
  output logic             out_last_o
);
  import pf_pkg::*;

  pair_t      pair_q;
  logic       pair_valid_q;
  logic [1:0] sel_q;
  logic       out_valid_q;
  letter_t    out_letter_q;
  logic       out_last_q;

  pos_t       pa, pb;
  coord_t     shift;
  letter_t    oa, ob;
  logic [1:0] last_idx;
  logic       out_load, pair_done;

  assign pa    = locate(cfg_i.square, pair_q.a);
  assign pb    = locate(cfg_i.square, pair_q.b);
  assign shift = cfg_i.decrypt ? SHIFT_DEC : SHIFT_ENC;

  always_comb begin
    if (pa.row == pb.row) begin
      oa = cfg_i.square[pa.row][add_mod5(pa.col, shift)];
      ob = cfg_i.square[pb.row][add_mod5(pb.col, shift)];
    end else if (pa.col == pb.col) begin
      oa = cfg_i.square[add_mod5(pa.row, shift)][pa.col];
      ob = cfg_i.square[add_mod5(pb.row, shift)][pb.col];
    end else begin
      oa = cfg_i.square[pa.row][pb.col];
      ob = cfg_i.square[pb.row][pa.col];
    end
  end

  assign last_idx     = pair_q.two ? 2'd3 : 2'd1;
  assign out_load     = pair_valid_q && (!out_valid_q || !out_stall_i);
  assign pair_done    = out_load && (sel_q == last_idx);
  assign pair_stall_o = pair_valid_q && !pair_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_valid_q <= 1'b0;
      sel_q        <= '0;
    end else if (pair_valid_i) begin
      pair_valid_q <= 1'b1;
      sel_q        <= '0;
    end else if (pair_done) begin
      pair_valid_q <= 1'b0;
      sel_q        <= '0;
    end else if (out_load) begin
      sel_q <= sel_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pair_valid_i) begin
      pair_q <= pair_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_letter_q <= sel_q[0] ? ob : oa;
      out_last_q   <= pair_q.last && (sel_q == last_idx);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_letter_o = out_letter_q;
  assign out_last_o   = out_last_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_valid_i |-> (!pair_valid_q || pair_done))
    else $error("pair register overwritten before drained");

  a_sel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pair_valid_q && !pair_q.two) |-> !sel_q[1])
    else $error("letter select past end of single pair");

  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_done |=> (!pair_valid_q || (sel_q == 2'd0)))
    else $error("pair register not freed or restarted after last letter");

endmodule

FILE: dv/playfair_digraph_cipher_unit_test.sv
// Self-checking testbench for the digraph cipher unit: directed and random letter streams.
`timescale 1ns / 1ps

module playfair_digraph_cipher_unit_test;
  import pf_pkg::*;

  typedef struct packed {
    letter_t letter;
    logic    last;
  } cipher_out_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [4:0]  in_letter_i;
  logic        in_last_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [4:0]  out_letter_o;
  logic        out_last_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [24:0] cfg_data_i;

  // Predictor state
  row_t        key_rows [5];
  logic        key_decrypt;
  letter_t     held_letter;
  logic        held_valid;
  cipher_out_t cipher_expect [$];

  int          mismatch_count;
  int          sender_idle_pct;
  int          receiver_idle_pct;
  bit          hold_request;
  int          hold_count;

  playfair_digraph_cipher_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_letter_i  (in_letter_i),
    .in_last_i    (in_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_letter_o (out_letter_o),
    .out_last_o   (out_last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int square_position(letter_t l);
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 5; c++) begin
        if (key_rows[r][c] == l) begin
          return r * 5 + c;
        end
      end
    end
    return 0;
  endfunction

  function automatic void predict_pair(letter_t a, letter_t b, logic last_flag);
    int      pa, pb, ra, ca, rb, cb, s;
    letter_t oa, ob;
    pa = square_position(a);
    pb = square_position(b);
    ra = pa / 5;
    ca = pa % 5;
    rb = pb / 5;
    cb = pb % 5;
    s  = key_decrypt ? int'(SHIFT_DEC) : int'(SHIFT_ENC);
    if (ra == rb) begin
      oa = key_rows[ra][(ca + s) % 5];
      ob = key_rows[rb][(cb + s) % 5];
    end else if (ca == cb) begin
      oa = key_rows[(ra + s) % 5][ca];
      ob = key_rows[(rb + s) % 5][cb];
    end else begin
      oa = key_rows[ra][cb];
      ob = key_rows[rb][ca];
    end
    cipher_expect.push_back({oa, 1'b0});
    cipher_expect.push_back({ob, last_flag});
  endfunction

  function automatic void predict_letter(letter_t raw, logic last_flag);
    letter_t l;
    l = (raw == LETTER_J) ? LETTER_I : raw;
    if (held_valid) begin
      if (!key_decrypt && l == held_letter) begin
        predict_pair(held_letter, LETTER_X, 1'b0);
        held_letter = l;
      end else begin
        predict_pair(held_letter, l, last_flag);
        held_valid = 1'b0;
      end
    end else begin
      held_letter = l;
      held_valid  = 1'b1;
    end
    if (last_flag && held_valid) begin
      predict_pair(held_letter, LETTER_X, 1'b1);
      held_valid = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string msg);
    $display("%0t ns mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(negedge clk_i) begin
    cipher_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (cipher_expect.size() == 0) begin
        report_mismatch($sformatf("unexpected letter %0d last %0b", out_letter_o, out_last_o));
      end else begin
        want = cipher_expect.pop_front();
        if (out_letter_o !== want.letter) begin
          report_mismatch($sformatf("letter %0d, want %0d", out_letter_o, want.letter));
        end
        if (out_last_o !== want.last) begin
          report_mismatch($sformatf("last %0b, want %0b", out_last_o, want.last));
        end
      end
    end
  end

  // Receiver stall, with an occasional long hold-off
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_count   = 300;
    end
    if (hold_count > 0) begin
      hold_count--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < receiver_idle_pct);
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_letter(letter_t l, logic last_flag);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_letter_i <= l;
    in_last_i   <= last_flag;
    forever begin
      @(negedge clk_i);
      if (!in_stall_o) begin
        @(posedge clk_i);
        predict_letter(l, last_flag);
        break;
      end
      @(posedge clk_i);
    end
  endtask

  task automatic send_text(string text);
    for (int i = 0; i < text.len(); i++) begin
      send_letter(letter_t'(text[i] - 8'd97), i == text.len() - 1);
    end
  endtask

  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    while (cipher_expect.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(reg_idx_e idx, logic [24:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    forever begin
      @(negedge clk_i);
      if (cfg_ready_o) begin
        @(posedge clk_i);
        break;
      end
      @(posedge clk_i);
    end
    if (idx == REG_DECRYPT) begin
      key_decrypt = data[0];
    end else begin
      key_rows[int'(idx) - int'(REG_ROW0)] = data;
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_square(row_t r0, row_t r1, row_t r2, row_t r3, row_t r4);
    write_register(REG_ROW0, r0);
    write_register(REG_ROW1, r1);
    write_register(REG_ROW2, r2);
    write_register(REG_ROW3, r3);
    write_register(REG_ROW4, r4);
  endtask

  task automatic write_shuffled_square();
    letter_t pool [25];
    letter_t t;
    row_t    rows [5];
    int      k, n;
    n = 0;
    for (int l = 0; l < 26; l++) begin
      if (letter_t'(l) != LETTER_J) begin
        pool[n] = letter_t'(l);
        n++;
      end
    end
    for (int i = 24; i > 0; i--) begin
      k       = $urandom_range(0, i);
      t       = pool[i];
      pool[i] = pool[k];
      pool[k] = t;
    end
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 5; c++) begin
        rows[r][c] = pool[r * 5 + c];
      end
    end
    write_square(rows[0], rows[1], rows[2], rows[3], rows[4]);
  endtask

  task automatic set_idling(int sender_pct, int receiver_pct);
    sender_idle_pct   = sender_pct;
    receiver_idle_pct = receiver_pct;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_square_encrypt();
    send_text("abafag");  // same row, same column, rectangle
    send_text("llij");    // doubled letter gets filler
    send_text("ijxxz");   // j paired as i
    send_text("xxy");     // x against the x filler
    send_text("qq");      // doubled on the final letter
    send_text("z");       // lone final letter
    wait_until_drained();
  endtask

  task automatic test_decrypt_mode();
    write_register(REG_DECRYPT, 25'd1);
    send_text("mmcde");
    wait_until_drained();
    write_register(REG_DECRYPT, 25'd0);
  endtask

  task automatic test_malformed_square();
    write_square('1, '0, {5{LETTER_J}}, 25'($urandom), 25'($urandom));
    for (int m = 0; m < 2; m++) begin
      write_register(REG_DECRYPT, 25'(m));
      send_text("jabberwockyz");
      send_text("xx");
      wait_until_drained();
    end
    write_register(REG_DECRYPT, 25'd0);
    write_square(ROW0_RESET, ROW1_RESET, ROW2_RESET, ROW3_RESET, ROW4_RESET);
  endtask

  task automatic test_backpressure();
    set_idling(0, 0);
    hold_request = 1'b1;
    send_text("pressurewithadeeppipeline");
    wait_until_drained();
  endtask

  task automatic test_random_traffic();
    letter_t prev;
    int      sent, len, pick;
    prev = '0;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0:       set_idling(21, 51);
        1:       set_idling(51, 21);
        default: set_idling(0, 0);
      endcase
      wait_until_drained();
      write_register(REG_DECRYPT, 25'(phase % 2));
      if ($urandom_range(0, 3) == 0) begin
        write_square(ROW0_RESET, ROW1_RESET, ROW2_RESET, ROW3_RESET, ROW4_RESET);
      end else begin
        write_shuffled_square();
      end
      sent = 0;
      while (sent < 28) begin
        len = $urandom_range(1, 9);
        for (int i = 0; i < len; i++) begin
          pick = $urandom_range(0, 99);
          if (pick < 15) begin
            prev = prev;
          end else if (pick < 22) begin
            prev = LETTER_J;
          end else if (pick < 30) begin
            prev = LETTER_X;
          end else begin
            prev = letter_t'($urandom_range(0, 25));
          end
          send_letter(prev, i == len - 1);
        end
        sent += len;
      end
    end
    wait_until_drained();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    in_letter_i  <= '0;
    in_last_i    <= 1'b0;
    out_stall_i  <= 1'b0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= REG_DECRYPT;
    cfg_data_i   <= '0;
    hold_request = 1'b0;
    hold_count   = 0;
    mismatch_count = 0;
    key_decrypt  = 1'b0;
    key_rows[0]  = ROW0_RESET;
    key_rows[1]  = ROW1_RESET;
    key_rows[2]  = ROW2_RESET;
    key_rows[3]  = ROW3_RESET;
    key_rows[4]  = ROW4_RESET;
    held_letter  = '0;
    held_valid   = 1'b0;
    set_idling(21, 51);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_square_encrypt();
    test_decrypt_mode();
    test_malformed_square();
    test_backpressure();
    test_random_traffic();

    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && cipher_expect.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
